/* rtl/gregorian_date_shift_unit_assert.svh */
// ----------------------------------------------------------------------------
// Gregorian date shift unit - assertion macros
// Concurrent assertion wrappers clocked on i_clk; empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef GREGORIAN_DATE_SHIFT_UNIT_ASSERT_SVH
`define GREGORIAN_DATE_SHIFT_UNIT_ASSERT_SVH

`ifndef SYNTH

// Checked only while out of reset.
`define GDS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Checked at every edge, reset included.
`define GDS_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) \
        else $error(msg);

`else

`define GDS_ASSERT(lbl, prop, msg)
`define GDS_ASSERT_RST(lbl, prop, msg)

`endif

`endif

/* rtl/gds_pkg.sv */
// ----------------------------------------------------------------------------
// Gregorian date shift unit - shared package
// Types, calendar constants and small calendar lookup functions.
// ----------------------------------------------------------------------------
package gds_pkg;

    // Width of the stored year; the year port itself stays 16 bits.
    localparam int YEAR_BITS = 16;
    localparam int FIELD_YEAR_W = 16;
    localparam int YEAR_CMP_W = (YEAR_BITS > FIELD_YEAR_W) ? YEAR_BITS : FIELD_YEAR_W;
    localparam int MAX_SHIFT = 365;

    typedef logic [YEAR_BITS-1:0]    t_year;
    typedef logic [FIELD_YEAR_W-1:0] t_field_year;
    typedef logic [YEAR_CMP_W-1:0]   t_year_wide;
    typedef logic [3:0]              t_month;
    typedef logic [4:0]              t_day;
    typedef logic [8:0]              t_doy;
    typedef logic [8:0]              t_res400;   // year mod 400
    typedef logic signed [10:0]      t_sdoy;     // day of year plus shift

    localparam t_year YEAR_MAX = '1;

    localparam t_sdoy SHIFT_HI         = t_sdoy'(MAX_SHIFT);
    localparam t_sdoy SHIFT_LO         = t_sdoy'(-MAX_SHIFT);
    localparam t_sdoy DAYS_LEAP_YEAR   = t_sdoy'(366);
    localparam t_sdoy DAYS_COMMON_YEAR = t_sdoy'(365);

    // ceil(2^15 / 25): exact quotient for 12-bit dividends
    localparam logic [10:0] RECIP25 = 11'd1311;
    localparam t_res400 RES400_LAST = 9'd399;

    typedef enum logic {
        REQ_LOAD  = 1'b0,
        REQ_SHIFT = 1'b1
    } t_req;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_DATE = 2'd1,
        ST_RANGE    = 2'd2
    } t_status;

    typedef struct packed {
        t_year   year;
        t_month  month;
        t_day    day;
        t_res400 res400;
    } t_date;

    typedef struct packed {
        t_date   date;
        t_status status;
    } t_step;

    localparam t_date DATE_RESET = '{year: t_year'(1), month: 4'd1, day: 5'd1,
                                     res400: 9'd1};

    // Leap: divisible by 4 and not by 100, or divisible by 400.
    function automatic logic is_leap(input t_res400 r);
        return (r[1:0] == 2'b00) && (r != 9'd100) && (r != 9'd200) && (r != 9'd300);
    endfunction

    function automatic t_res400 res_next(input t_res400 r);
        return (r == RES400_LAST) ? '0 : r + 9'd1;
    endfunction

    function automatic t_res400 res_prev(input t_res400 r);
        return (r == '0) ? RES400_LAST : r - 9'd1;
    endfunction

    // y mod 400 = 16 * ((y >> 4) mod 25) + (y mod 16)
    function automatic t_res400 year_res400(input t_field_year y);
        logic [11:0] z;
        logic [22:0] prod;
        logic [7:0]  q;
        logic [11:0] r25;
        z    = y[15:4];
        prod = 23'(z) * 23'(RECIP25);
        q    = prod[22:15];
        r25  = z - (12'(q) * 12'd25);
        return {r25[4:0], y[3:0]};
    endfunction

    function automatic t_day month_len(input t_month m, input logic leap);
        case (m)
            4'd2: begin
                return leap ? 5'd29 : 5'd28;
            end
            4'd4, 4'd6, 4'd9, 4'd11: begin
                return 5'd30;
            end
            default: begin
                return 5'd31;
            end
        endcase
    endfunction

    // Days in the year before the first of month m.
    function automatic t_doy days_before(input t_month m, input logic leap);
        t_doy base;
        case (m)
            4'd1:    base = 9'd0;
            4'd2:    base = 9'd31;
            4'd3:    base = 9'd59;
            4'd4:    base = 9'd90;
            4'd5:    base = 9'd120;
            4'd6:    base = 9'd151;
            4'd7:    base = 9'd181;
            4'd8:    base = 9'd212;
            4'd9:    base = 9'd243;
            4'd10:   base = 9'd273;
            4'd11:   base = 9'd304;
            4'd12:   base = 9'd334;
            default: base = 9'd0;
        endcase
        return base + t_doy'(leap && (m > 4'd2));
    endfunction

endpackage

/* rtl/gregorian_date_shift_unit.sv */
// ----------------------------------------------------------------------------
// Gregorian date shift unit
// Holds one calendar date; loads a checked date or shifts it by up to a year.
// ----------------------------------------------------------------------------
// An accepted beat waits in the input register, then moves to the result register once that is free.
// Throughput: one request per cycle; the input register and the result
//   register are the only stages, so a stalled result stalls the input.
// Reset (synchronous, active low): date 1-01-01, both stages empty.
// ----------------------------------------------------------------------------
`include "gregorian_date_shift_unit_assert.svh"

module gregorian_date_shift_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,

    // request channel
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_req_type,
    input  logic [15:0]       i_in_year,
    input  logic [3:0]        i_in_month,
    input  logic [4:0]        i_in_day,
    input  logic signed [9:0] i_day_shift,

    // result channel
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [15:0]       o_out_year,
    output logic [3:0]        o_out_month,
    output logic [4:0]        o_out_day,
    output logic [1:0]        o_status
);

    // ------------------------------------------------------------------
    // Input register: holds one request beat.
    // ------------------------------------------------------------------
    logic                 r_s1_valid;
    gds_pkg::t_req        r_s1_req;
    gds_pkg::t_field_year r_s1_year;
    gds_pkg::t_month      r_s1_month;
    gds_pkg::t_day        r_s1_day;
    logic signed [9:0]    r_s1_shift;

    // Stored calendar date, with year mod 400 kept alongside for leap tests.
    gds_pkg::t_date       r_date;

    // Result register.
    logic                 r_out_valid;
    gds_pkg::t_field_year r_out_year;
    gds_pkg::t_month      r_out_month;
    gds_pkg::t_day        r_out_day;
    gds_pkg::t_status     r_out_status;

    logic                 n_s1_valid;
    logic                 n_out_valid;
    logic                 in_take;
    logic                 adv;
    gds_pkg::t_step       step_res;

    // Advance the input beat whenever the result register is free or drains.
    assign adv        = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || adv;
    assign in_take    = i_in_valid && o_in_ready;

    assign n_s1_valid  = in_take || (r_s1_valid && !adv);
    assign n_out_valid = adv || (r_out_valid && !i_out_ready);

    // ------------------------------------------------------------------
    // Date arithmetic: load check, or shift with year carry.
    // ------------------------------------------------------------------
    gds_step u_step (
        .i_date      (r_date),
        .i_req       (r_s1_req),
        .i_in_year   (r_s1_year),
        .i_in_month  (r_s1_month),
        .i_in_day    (r_s1_day),
        .i_day_shift (r_s1_shift),
        .o_step      (step_res)
    );

    // Control and stored date.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_date      <= gds_pkg::DATE_RESET;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
            if (adv) begin
                r_date <= step_res.date;
            end
        end
    end

    // Payload capture; no reset needed.
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_req   <= gds_pkg::t_req'(i_req_type);
            r_s1_year  <= i_in_year;
            r_s1_month <= i_in_month;
            r_s1_day   <= i_in_day;
            r_s1_shift <= i_day_shift;
        end
        if (adv) begin
            r_out_year   <= gds_pkg::t_field_year'(step_res.date.year);
            r_out_month  <= step_res.date.month;
            r_out_day    <= step_res.date.day;
            r_out_status <= step_res.status;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_year  = r_out_year;
    assign o_out_month = r_out_month;
    assign o_out_day   = r_out_day;
    assign o_status    = r_out_status;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `GDS_ASSERT(a_date_legal,
        (r_date.month >= 4'd1) && (r_date.month <= 4'd12) && (r_date.day >= 5'd1)
            && (r_date.day <= gds_pkg::month_len(r_date.month,
                                                 gds_pkg::is_leap(r_date.res400))),
        "stored date is not a calendar date")
    `GDS_ASSERT(a_err_keeps_date,
        (adv && (step_res.status != gds_pkg::ST_OK)) |=> $stable(r_date),
        "refused request changed the stored date")
    `GDS_ASSERT(a_out_mirrors_date,
        o_out_valid |-> ((o_out_year == gds_pkg::t_field_year'(r_date.year))
            && (o_out_month == r_date.month) && (o_out_day == r_date.day)),
        "result beat differs from stored date")
    `GDS_ASSERT_RST(a_reset_clears,
        !i_rst_n |=> (!o_out_valid && o_in_ready && (r_date == gds_pkg::DATE_RESET)),
        "reset did not clear the unit")

endmodule

/* rtl/gds_step.sv */
// ----------------------------------------------------------------------------
// Gregorian date step
// Next stored date and status for one load or shift request.
// ----------------------------------------------------------------------------
module gds_step (
    input  gds_pkg::t_date       i_date,
    input  gds_pkg::t_req        i_req,
    input  gds_pkg::t_field_year i_in_year,
    input  gds_pkg::t_month      i_in_month,
    input  gds_pkg::t_day        i_in_day,
    input  logic signed [9:0]    i_day_shift,
    output gds_pkg::t_step       o_step
);

    // load check
    gds_pkg::t_res400 ld_res;
    logic             ld_leap;
    logic             ld_ok;

    // shift
    logic             cur_leap;
    logic             prv_leap;
    logic             nxt_leap;
    gds_pkg::t_res400 prv_res;
    gds_pkg::t_res400 nxt_res;
    gds_pkg::t_sdoy   sh_ext;
    gds_pkg::t_sdoy   sh_clamp;
    gds_pkg::t_doy    doy_cur;
    gds_pkg::t_sdoy   doy_new;
    gds_pkg::t_sdoy   len_cur;
    gds_pkg::t_sdoy   len_prv;
    gds_pkg::t_sdoy   sum_prv;
    gds_pkg::t_sdoy   sum_nxt;
    logic             under;
    logic             over;

    logic             range_err;
    gds_pkg::t_year   tgt_year;
    gds_pkg::t_res400 tgt_res;
    logic             tgt_leap;
    gds_pkg::t_doy    tgt_doy;
    gds_pkg::t_month  tgt_month;
    gds_pkg::t_doy    tgt_day_w;

    assign ld_res  = gds_pkg::year_res400(i_in_year);
    assign ld_leap = gds_pkg::is_leap(ld_res);
    assign ld_ok   = (i_in_year != '0)
                  && (gds_pkg::t_year_wide'(i_in_year)
                      <= gds_pkg::t_year_wide'(gds_pkg::YEAR_MAX))
                  && (i_in_month >= 4'd1) && (i_in_month <= 4'd12)
                  && (i_in_day != '0)
                  && (i_in_day <= gds_pkg::month_len(i_in_month, ld_leap));

    assign prv_res  = gds_pkg::res_prev(i_date.res400);
    assign nxt_res  = gds_pkg::res_next(i_date.res400);
    assign cur_leap = gds_pkg::is_leap(i_date.res400);
    assign prv_leap = gds_pkg::is_leap(prv_res);
    assign nxt_leap = gds_pkg::is_leap(nxt_res);

    // Clamp the shift to the supported window.
    assign sh_ext   = {i_day_shift[9], i_day_shift};
    assign sh_clamp = (sh_ext > gds_pkg::SHIFT_HI) ? gds_pkg::SHIFT_HI :
                      (sh_ext < gds_pkg::SHIFT_LO) ? gds_pkg::SHIFT_LO : sh_ext;

    assign doy_cur = gds_pkg::days_before(i_date.month, cur_leap)
                   + gds_pkg::t_doy'(i_date.day);
    assign doy_new = $signed({2'b00, doy_cur}) + sh_clamp;

    assign len_cur = cur_leap ? gds_pkg::DAYS_LEAP_YEAR : gds_pkg::DAYS_COMMON_YEAR;
    assign len_prv = prv_leap ? gds_pkg::DAYS_LEAP_YEAR : gds_pkg::DAYS_COMMON_YEAR;
    assign sum_prv = doy_new + len_prv;
    assign sum_nxt = doy_new - len_cur;

    // Day of year zero or below lands in the previous year.
    assign under = doy_new[10] || (doy_new == '0);
    assign over  = !under && (doy_new > len_cur);

    always_comb begin
        range_err = 1'b0;
        tgt_year  = i_date.year;
        tgt_res   = i_date.res400;
        tgt_leap  = cur_leap;
        tgt_doy   = doy_new[8:0];
        if (under) begin
            if (i_date.year <= gds_pkg::t_year'(1)) begin
                range_err = 1'b1;
            end else begin
                tgt_year = i_date.year - gds_pkg::t_year'(1);
                tgt_res  = prv_res;
                tgt_leap = prv_leap;
                tgt_doy  = sum_prv[8:0];
            end
        end else if (over) begin
            if (i_date.year == gds_pkg::YEAR_MAX) begin
                range_err = 1'b1;
            end else begin
                tgt_year = i_date.year + gds_pkg::t_year'(1);
                tgt_res  = nxt_res;
                tgt_leap = nxt_leap;
                tgt_doy  = sum_nxt[8:0];
            end
        end
    end

    // First month whose end reaches the day of year; December otherwise.
    always_comb begin
        tgt_month = 4'd12;
        for (int i = 11; i >= 1; i--) begin
            if (tgt_doy <= gds_pkg::days_before(4'(i + 1), tgt_leap)) begin
                tgt_month = 4'(i);
            end
        end
    end

    assign tgt_day_w = tgt_doy - gds_pkg::days_before(tgt_month, tgt_leap);

    always_comb begin
        o_step.date   = i_date;
        o_step.status = gds_pkg::ST_OK;
        case (i_req)
            gds_pkg::REQ_LOAD: begin
                if (ld_ok) begin
                    o_step.date.year   = gds_pkg::t_year'(i_in_year);
                    o_step.date.month  = i_in_month;
                    o_step.date.day    = i_in_day;
                    o_step.date.res400 = ld_res;
                end else begin
                    o_step.status = gds_pkg::ST_BAD_DATE;
                end
            end
            gds_pkg::REQ_SHIFT: begin
                if (range_err) begin
                    o_step.status = gds_pkg::ST_RANGE;
                end else begin
                    o_step.date.year   = tgt_year;
                    o_step.date.month  = tgt_month;
                    o_step.date.day    = tgt_day_w[4:0];
                    o_step.date.res400 = tgt_res;
                end
            end
            default: begin
                o_step.status = gds_pkg::ST_OK;
            end
        endcase
    end

endmodule

/* bench/gds_date_checker.sv */
// ----------------------------------------------------------------------------
// Gregorian date shift unit - date checker
// Watches both channels, keeps its own copy of the stored date, predicts
// the result beat of every accepted request and compares it field by field.
// ----------------------------------------------------------------------------
module gds_date_checker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_ready,
    input  logic              i_req_type,
    input  logic [15:0]       i_in_year,
    input  logic [3:0]        i_in_month,
    input  logic [4:0]        i_in_day,
    input  logic signed [9:0] i_day_shift,
    input  logic              i_out_valid,
    input  logic              i_out_ready,
    input  logic [15:0]       i_out_year,
    input  logic [3:0]        i_out_month,
    input  logic [4:0]        i_out_day,
    input  logic [1:0]        i_status,
    output int                o_fail_count,
    output int                o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint YEAR_LIMIT = (longint'(1) << gds_pkg::YEAR_BITS) - 1;

    typedef struct packed {
        gds_pkg::t_field_year year;
        gds_pkg::t_month      month;
        gds_pkg::t_day        day;
        gds_pkg::t_status     status;
    } t_date_beat;

    t_date_beat expected_dates[$];

    longint held_year;
    int     held_month;
    int     held_day;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        o_fail_count++;
    endtask

    function automatic bit leap_year(input longint y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic int year_days(input longint y);
        return leap_year(y) ? 366 : 365;
    endfunction

    function automatic int month_days(input longint y, input int m);
        if (m == 2) begin
            return leap_year(y) ? 29 : 28;
        end else if (m == 4 || m == 6 || m == 9 || m == 11) begin
            return 30;
        end
        return 31;
    endfunction

    function automatic int ordinal_day();
        int total;
        total = held_day;
        for (int mo = 1; mo < held_month; mo++) begin
            total += month_days(held_year, mo);
        end
        return total;
    endfunction

    // Walk the months of year y until the ordinal falls inside one.
    function automatic void place_ordinal(input longint y, input int doy);
        int rest;
        rest = doy;
        for (int mo = 1; mo <= 12; mo++) begin
            if (rest <= month_days(y, mo) || mo == 12) begin
                held_year  = y;
                held_month = mo;
                held_day   = rest;
                return;
            end
            rest -= month_days(y, mo);
        end
    endfunction

    function automatic t_date_beat predict_request(input logic kind, input logic [15:0] y,
                                                   input logic [3:0] m, input logic [4:0] d,
                                                   input logic signed [9:0] shift);
        gds_pkg::t_status st;
        int               n;
        int               doy;
        st = gds_pkg::ST_OK;
        if (kind == gds_pkg::REQ_LOAD) begin
            if (y >= 1 && longint'(y) <= YEAR_LIMIT && m >= 1 && m <= 12 && d >= 1 &&
                int'(d) <= month_days(longint'(y), int'(m))) begin
                held_year  = longint'(y);
                held_month = int'(m);
                held_day   = int'(d);
            end else begin
                st = gds_pkg::ST_BAD_DATE;
            end
        end else begin
            n = int'(shift);
            if (n > gds_pkg::MAX_SHIFT) n = gds_pkg::MAX_SHIFT;
            if (n < -gds_pkg::MAX_SHIFT) n = -gds_pkg::MAX_SHIFT;
            doy = ordinal_day() + n;
            if (doy <= 0) begin
                // ordinal zero and below land in the year before
                if (held_year <= 1) begin
                    st = gds_pkg::ST_RANGE;
                end else begin
                    place_ordinal(held_year - 1, doy + year_days(held_year - 1));
                end
            end else if (doy > year_days(held_year)) begin
                if (held_year >= YEAR_LIMIT) begin
                    st = gds_pkg::ST_RANGE;
                end else begin
                    place_ordinal(held_year + 1, doy - year_days(held_year));
                end
            end else begin
                place_ordinal(held_year, doy);
            end
        end
        return '{year: gds_pkg::t_field_year'(held_year), month: gds_pkg::t_month'(held_month),
                 day: gds_pkg::t_day'(held_day), status: st};
    endfunction

    always @(posedge i_clk) begin
        t_date_beat got;
        t_date_beat want;
        if (!i_rst_n) begin
            held_year  = 1;
            held_month = 1;
            held_day   = 1;
            expected_dates.delete();
        end else begin
            // retire the oldest expectation before queuing a new one
            if (i_out_valid && i_out_ready) begin
                got = '{year: i_out_year, month: i_out_month, day: i_out_day,
                        status: gds_pkg::t_status'(i_status)};
                if (expected_dates.size() == 0) begin
                    report_mismatch("result beat with nothing expected", int'(got.year), 0);
                end else begin
                    want = expected_dates.pop_front();
                    if (got.year != want.year)
                        report_mismatch("year", int'(got.year), int'(want.year));
                    if (got.month != want.month)
                        report_mismatch("month", int'(got.month), int'(want.month));
                    if (got.day != want.day)
                        report_mismatch("day", int'(got.day), int'(want.day));
                    if (got.status != want.status)
                        report_mismatch("status", int'(got.status), int'(want.status));
                end
            end
            if (i_in_valid && i_in_ready) begin
                expected_dates.push_back(predict_request(i_req_type, i_in_year, i_in_month,
                                                         i_in_day, i_day_shift));
            end
        end
        o_pending <= expected_dates.size();
    end

endmodule

/* bench/tb.sv */
// ----------------------------------------------------------------------------
// Gregorian date shift unit - testbench top
// Drives load and shift requests with random gaps, stalls the result side,
// and leaves prediction and comparison to the date checker beside the block.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEM_COUNT  = 1700;
    localparam int LONG_HOLD   = 300;
    localparam int CYCLE_LIMIT = 400000;

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_in_valid  = 1'b0;
    logic              o_in_ready;
    logic              i_req_type  = 1'b0;
    logic [15:0]       i_in_year   = '0;
    logic [3:0]        i_in_month  = '0;
    logic [4:0]        i_in_day    = '0;
    logic signed [9:0] i_day_shift = '0;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    logic [15:0]       o_out_year;
    logic [3:0]        o_out_month;
    logic [4:0]        o_out_day;
    logic [1:0]        o_status;

    int     fail_count;
    int     pending;
    longint cycle_count;

    // When set, neither side idles: back-to-back beats on both channels.
    bit quiet_phase   = 1'b0;
    // Bump to ask the result side for one long hold-off.
    int hold_requests = 0;
    int holds_served  = 0;

    gregorian_date_shift_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_req_type  (i_req_type),
        .i_in_year   (i_in_year),
        .i_in_month  (i_in_month),
        .i_in_day    (i_in_day),
        .i_day_shift (i_day_shift),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_year  (o_out_year),
        .o_out_month (o_out_month),
        .o_out_day   (o_out_day),
        .o_status    (o_status)
    );

    gds_date_checker u_date_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_req_type   (i_req_type),
        .i_in_year    (i_in_year),
        .i_in_month   (i_in_month),
        .i_in_day     (i_in_day),
        .i_day_shift  (i_day_shift),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_out_year   (o_out_year),
        .i_out_month  (o_out_month),
        .i_out_day    (o_out_day),
        .i_status     (o_status),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Abort a hung run; the bound covers every beat waiting out the longest
    // gap and stall many times over.
    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count <= CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("[gregorian_date_shift_unit] ERROR");
        $finish;
    end

    // Result side: draw a stall per beat, then hold ready until a beat lands.
    // A pending hold-off request replaces the stall with a long one, so the
    // two internal stages fill up and the request channel backs off.
    initial begin : result_sink
        int stall;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            stall = quiet_phase ? 0 : $urandom_range(0, 14);
            if (holds_served != hold_requests) begin
                stall = LONG_HOLD;
                holds_served++;
            end
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    // Offer one request beat after a random gap and hold it until accepted.
    // Valid drops only when a gap follows, so it never toggles within a step.
    task automatic send_beat(input gds_pkg::t_req kind, input logic [15:0] y,
                             input logic [3:0] m, input logic [4:0] d,
                             input logic signed [9:0] shift);
        int gap;
        gap = quiet_phase ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_req_type  <= kind;
        i_in_year   <= y;
        i_in_month  <= m;
        i_in_day    <= d;
        i_day_shift <= shift;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // Fields a request does not use carry random bits.
    task automatic load_date(input logic [15:0] y, input logic [3:0] m, input logic [4:0] d);
        send_beat(gds_pkg::REQ_LOAD, y, m, d, 10'($urandom));
    endtask

    task automatic shift_days(input logic signed [9:0] n);
        send_beat(gds_pkg::REQ_SHIFT, 16'($urandom), 4'($urandom), 5'($urandom), n);
    endtask

    // Drop valid and wait until every predicted beat has come back.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    function automatic logic signed [9:0] random_shift();
        int sel;
        int v;
        sel = $urandom_range(0, 9);
        if (sel < 5) begin
            v = $urandom_range(0, 730) - 365;
        end else if (sel < 7) begin
            v = $urandom_range(0, 6) - 3;
        end else if (sel == 7) begin
            v = $urandom;                       // full 10-bit range, clamping included
        end else if (sel == 8) begin
            v = $urandom_range(0, 1) ? $urandom_range(364, 511) : -$urandom_range(364, 512);
        end else begin
            v = $urandom_range(0, 1) ? $urandom_range(28, 31) : -$urandom_range(28, 31);
        end
        return 10'(v);
    endfunction

    // Lean on the range ends and on century years, where leap rules bite.
    function automatic logic [15:0] random_year();
        int sel;
        sel = $urandom_range(0, 4);
        if (sel == 0) return 16'($urandom_range(1, 65535));
        if (sel == 1) return 16'($urandom_range(1, 3));
        if (sel == 2) return 16'($urandom_range(65533, 65535));
        if (sel == 3) return 16'(100 * $urandom_range(1, 655));
        return 16'($urandom_range(1896, 2104));
    endfunction

    function automatic logic [4:0] random_day();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 6) return 5'($urandom_range(1, 28));
        if (sel < 9) return 5'($urandom_range(28, 31));   // month ends, some refused
        return 5'd1;
    endfunction

    initial begin : stimulus
        int pick;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: reset date, year-one floor, refused loads, leap days,
        // ordinal zero, clamped shifts and the top of the year range.
        shift_days(10'sd0);
        shift_days(-10'sd1);
        shift_days(-10'sd512);
        load_date(16'd0, 4'd1, 5'd1);
        load_date(16'd2000, 4'd0, 5'd1);
        load_date(16'd2000, 4'd13, 5'd1);
        load_date(16'd2000, 4'd15, 5'd31);
        load_date(16'd2000, 4'd1, 5'd0);
        load_date(16'd2001, 4'd4, 5'd31);
        load_date(16'd1900, 4'd2, 5'd29);
        load_date(16'd2000, 4'd2, 5'd29);
        shift_days(10'sd0);
        load_date(16'd2024, 4'd2, 5'd29);
        shift_days(10'sd365);
        load_date(16'd2001, 4'd1, 5'd1);
        shift_days(-10'sd1);
        load_date(16'd2000, 4'd3, 5'd1);
        shift_days(-10'sd61);
        load_date(16'd65535, 4'd12, 5'd31);
        shift_days(10'sd1);
        shift_days(10'sd511);
        load_date(16'd65535, 4'd1, 5'd1);
        shift_days(-10'sd365);
        load_date(16'd1, 4'd1, 5'd1);
        shift_days(10'sd365);

        // Random: mostly shifts and well-formed loads, some raw noise.
        for (int k = 0; k < ITEM_COUNT; k++) begin
            if (k % 100 == 0) quiet_phase = ($urandom_range(0, 3) == 0);
            if (k == 400) hold_requests++;
            if (k == 900) drain_results();
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                shift_days(random_shift());
            end else if (pick < 85) begin
                load_date(random_year(), 4'($urandom_range(1, 12)), random_day());
            end else begin
                load_date(16'($urandom), 4'($urandom), 5'($urandom));
            end
        end

        // Wait out every result and let the pipeline settle before the verdict.
        drain_results();
        repeat (10) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("[gregorian_date_shift_unit] OK");
        end else begin
            $display("[gregorian_date_shift_unit] ERROR");
        end
        $finish;
    end

endmodule
